[rtl/frm_pkg.sv]
package frm_pkg;

    localparam int SAMPLES_DEF = 8;

    localparam int TS_W    = 32;
    localparam int FRAME_W = 12;
    localparam int FPS_W   = 20;
    localparam int SUM_W   = 26;
    localparam int EMPTY_W = 7;
    localparam int SCALE_W = 18;
    localparam int NUM_W   = FRAME_W + SCALE_W;
    localparam int ITER_W  = 5;

    localparam logic [FRAME_W-1:0] FRAME_MAX = 12'd4095;
    localparam logic [TS_W-1:0]    WINDOW_MS = 32'd1000;
    // 1000 ms per second times 256 for the Q12.8 fraction
    localparam logic [SCALE_W-1:0] FPS_SCALE = 18'd256000;

    // The fps quotient is below 2^20, so the top NUM_W-FPS_W bits are skipped
    localparam logic [ITER_W-1:0] FPS_ITERS = 5'd20;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef struct packed {
        logic            command;
        logic [TS_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic               window_closed;
        logic [FPS_W-1:0]   fps_q8;
        logic [FPS_W-1:0]   average_fps_q8;
        logic               average_ready;
        logic [EMPTY_W-1:0] empty_slots;
    } t_out_item;

endpackage

[rtl/frm_in_if.sv]
interface frm_in_if;
    logic              valid;
    logic              ready;
    frm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/frm_out_if.sv]
interface frm_out_if;
    logic               valid;
    logic               ready;
    frm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/frame_rate_meter_moving_average.sv]
// Frame rate meter with a moving average over SAMPLES closed windows.
// i_in carries one item per start command or presented frame, each with a
// millisecond timestamp; o_out returns exactly one result item per input item.
// A start command, or a frame that does not close its window, gives its result
// in the cycle after acceptance. A frame that closes a window (more than 1000 ms
// since the window start) gives its result after these steps: the product
// frames*256000, the restoring divider for fps, a step to shift the sample
// window and a step for the mean, which multiplies the running sum by a
// rounded-up reciprocal of SAMPLES. One multiplier serves both products, and
// i_in.ready stays low until the block is idle again, so a new item is not
// taken before a closing frame is through.
// The result sits in an output register; a new item is taken while that
// register is being emptied in the same cycle, so a stalled receiver simply
// holds i_in.ready low once the register is full.
// Synchronous reset (i_rst_n low) clears the window start, frame count, the
// sample window, the running sum, the latest values, the ready flag and
// any pending result; the empty slot count returns to SAMPLES.
module frame_rate_meter_moving_average #(
    parameter int SAMPLES = frm_pkg::SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    frm_in_if.sink        i_in,
    frm_out_if.source     o_out
);

    localparam int CNT_W   = $clog2(SAMPLES + 1);
    localparam int AVG_SH  = frm_pkg::SUM_W + $clog2(SAMPLES);
    localparam int RECIP_W = frm_pkg::SUM_W + 1;
    localparam int PROD_W  = frm_pkg::SUM_W + RECIP_W;
    // Rounded up so that the product shifted by AVG_SH is the truncated mean
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SH) / 64'(SAMPLES)) + 64'd1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL     = 3'd1;
    localparam logic [2:0] S_DIV_FPS = 3'd2;
    localparam logic [2:0] S_UPD     = 3'd3;
    localparam logic [2:0] S_FIN     = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [frm_pkg::TS_W-1:0]           r_start, n_start;
    logic [frm_pkg::FRAME_W-1:0]        r_frames, n_frames;
    logic [frm_pkg::FPS_W-1:0]          r_win [SAMPLES];
    logic [frm_pkg::FPS_W-1:0]          n_win [SAMPLES];
    logic [frm_pkg::SUM_W-1:0]          r_sum, n_sum;
    logic [frm_pkg::FPS_W-1:0]          r_fps, n_fps;
    logic [frm_pkg::FPS_W-1:0]          r_avg, n_avg;
    logic                               r_ready_flag, n_ready_flag;
    logic [CNT_W-1:0]                   r_empty, n_empty;
    logic [frm_pkg::TS_W-1:0]           r_den, n_den;
    logic [frm_pkg::TS_W-1:0]           r_rem, n_rem;
    logic [frm_pkg::NUM_W-1:0]          r_quo, n_quo;
    logic [frm_pkg::ITER_W-1:0]         r_iter, n_iter;
    logic                               r_out_valid, n_out_valid;
    frm_pkg::t_out_item                 r_out, n_out;

    logic                               accept;
    logic [frm_pkg::TS_W-1:0]           elapsed;
    logic [frm_pkg::FRAME_W-1:0]        frames_inc;
    logic [frm_pkg::SUM_W-1:0]          mul_a;
    logic [RECIP_W-1:0]                 mul_b;
    logic [PROD_W-1:0]                  prod;
    logic [frm_pkg::NUM_W-1:0]          num;
    logic [frm_pkg::FPS_W-1:0]          avg_new;
    logic [frm_pkg::TS_W:0]             rem_sh;
    logic [frm_pkg::TS_W:0]             rem_diff;
    logic                               rem_ge;
    logic [frm_pkg::FPS_W-1:0]          fps_new;
    logic [CNT_W-1:0]                   empty_drop;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign elapsed    = i_in.data.now_ms - r_start;
    assign frames_inc = (r_frames < frm_pkg::FRAME_MAX) ?
                        r_frames + {{(frm_pkg::FRAME_W-1){1'b0}}, 1'b1} : r_frames;

    // Shared multiplier: fps numerator in S_MUL, mean of the window otherwise
    assign mul_a   = (r_state == S_MUL) ? frm_pkg::SUM_W'(r_frames) : r_sum;
    assign mul_b   = (r_state == S_MUL) ? RECIP_W'(frm_pkg::FPS_SCALE) : AVG_RECIP;
    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign num     = prod[frm_pkg::NUM_W-1:0];
    assign avg_new = prod[AVG_SH +: frm_pkg::FPS_W];

    // Restoring divider step: one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[frm_pkg::NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign rem_ge   = (rem_sh >= {1'b0, r_den});

    assign fps_new    = r_quo[frm_pkg::FPS_W-1:0];
    assign empty_drop = (r_win[0] == '0) ? r_empty - CNT_W'(1) : r_empty;

    always_comb begin
        n_state      = r_state;
        n_start      = r_start;
        n_frames     = r_frames;
        n_win        = r_win;
        n_sum        = r_sum;
        n_fps        = r_fps;
        n_avg        = r_avg;
        n_ready_flag = r_ready_flag;
        n_empty      = r_empty;
        n_den        = r_den;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_iter       = r_iter;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.window_closed  = 1'b0;
                    n_out.fps_q8         = r_fps;
                    n_out.average_fps_q8 = r_avg;
                    n_out.average_ready  = r_ready_flag;
                    n_out.empty_slots    = frm_pkg::EMPTY_W'(r_empty);
                    if (i_in.data.command == frm_pkg::CMD_START) begin
                        n_start     = i_in.data.now_ms;
                        n_out_valid = 1'b1;
                    end else begin
                        n_frames = frames_inc;
                        if (elapsed > frm_pkg::WINDOW_MS) begin
                            n_den   = elapsed;
                            n_start = i_in.data.now_ms;
                            n_state = S_MUL;
                        end else begin
                            n_out_valid = 1'b1;
                        end
                    end
                end
            end
            S_MUL: begin
                // Skip the quotient bits that are known to be zero
                n_rem = {{(frm_pkg::TS_W-frm_pkg::NUM_W+frm_pkg::FPS_W){1'b0}},
                         num[frm_pkg::NUM_W-1:frm_pkg::FPS_W]};
                n_quo = {num[frm_pkg::FPS_W-1:0],
                         {(frm_pkg::NUM_W-frm_pkg::FPS_W){1'b0}}};
                n_iter   = frm_pkg::FPS_ITERS;
                n_frames = '0;
                n_state  = S_DIV_FPS;
            end
            S_DIV_FPS: begin
                n_rem  = rem_ge ? rem_diff[frm_pkg::TS_W-1:0] : rem_sh[frm_pkg::TS_W-1:0];
                n_quo  = {r_quo[frm_pkg::NUM_W-2:0], rem_ge};
                n_iter = r_iter - frm_pkg::ITER_W'(1);
                if (r_iter == frm_pkg::ITER_W'(1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // Drop the oldest sample, append the new one
                n_sum = r_sum - frm_pkg::SUM_W'(r_win[0]) + frm_pkg::SUM_W'(fps_new);
                for (int i = 0; i < SAMPLES - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[SAMPLES-1] = fps_new;
                n_empty = (fps_new == '0) ? empty_drop + CNT_W'(1) : empty_drop;
                n_fps   = fps_new;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_avg        = avg_new;
                n_ready_flag = r_ready_flag || (r_empty == '0);
                n_out.window_closed  = 1'b1;
                n_out.fps_q8         = r_fps;
                n_out.average_fps_q8 = avg_new;
                n_out.average_ready  = n_ready_flag;
                n_out.empty_slots    = frm_pkg::EMPTY_W'(r_empty);
                n_out_valid          = 1'b1;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start      <= '0;
            r_frames     <= '0;
            r_sum        <= '0;
            r_fps        <= '0;
            r_avg        <= '0;
            r_ready_flag <= 1'b0;
            r_empty      <= CNT_W'(SAMPLES);
            r_out_valid  <= 1'b0;
            for (int i = 0; i < SAMPLES; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_start      <= n_start;
            r_frames     <= n_frames;
            r_sum        <= n_sum;
            r_fps        <= n_fps;
            r_avg        <= n_avg;
            r_ready_flag <= n_ready_flag;
            r_empty      <= n_empty;
            r_out_valid  <= n_out_valid;
            r_win        <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_iter <= n_iter;
        r_out  <= n_out;
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input taken while the divider is busy");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready_flag |=> r_ready_flag)
        else $error("ready flag cleared without reset");

    a_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty <= CNT_W'(SAMPLES))
        else $error("empty slot count exceeds the window depth");

    a_fps_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_quo[frm_pkg::NUM_W-1:frm_pkg::FPS_W] == '0))
        else $error("fps quotient overflowed its field");

endmodule
